// ===== design/acvs_pkg.sv =====
// Shared types, constants and arithmetic helpers for the chain integrator.
package acvs_pkg;
   localparam int VAL_W = 48;
   localparam int OP_W = VAL_W + 2;
   localparam int PROD_W = 2 * OP_W;
   localparam logic signed [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] NEG_MAX = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic [1:0] REG_KAPPA = 2'd0;
   localparam logic [1:0] REG_ALPHA = 2'd1;
   localparam logic [1:0] REG_DT = 2'd2;
   localparam logic [1:0] REG_COUNT = 2'd3;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic signed [OP_W-1:0] wide_type;

   typedef struct packed {
      logic start;
      logic [VAL_W-1:0] num;
      logic [VAL_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic busy;
      val_type quot;
   } div_rsp_type;

   function automatic val_type sat_wide(input logic signed [VAL_W+1:0] x);
      val_type r;
      if (x > $signed({{2{1'b0}}, POS_MAX})) r = POS_MAX;
      else if (x < $signed({{2{1'b1}}, NEG_MAX})) r = NEG_MAX;
      else r = x[VAL_W-1:0];
      return r;
   endfunction
endpackage

// ===== design/acvs_div.sv =====
// Restoring divider: one quotient bit per cycle, rounded and saturated.
module acvs_div #(
   parameter int FRAC_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  acvs_pkg::div_req_type req,
   output acvs_pkg::div_rsp_type rsp
);
   import acvs_pkg::*;
   localparam int DW = VAL_W + FRAC_BITS;
   localparam int CW = $clog2(DW + 1);

   logic busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in, ovf_ff, ovf_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [VAL_W:0] rem_ff, rem_in;
   logic [VAL_W:0] quo_ff, quo_in;
   logic [VAL_W-1:0] den_ff, den_in;
   logic [VAL_W:0] shifted;
   logic [VAL_W+1:0] twice;
   logic [VAL_W:0] mag;
   logic [VAL_W-1:0] fmag;
   val_type res_ff, res_in;

   always_comb begin
      busy_in = busy_ff; done_in = 1'b0; neg_in = neg_ff; ovf_in = ovf_ff;
      cnt_in = cnt_ff; dvd_in = dvd_ff; rem_in = rem_ff; quo_in = quo_ff;
      den_in = den_ff; res_in = res_ff;
      fmag = req.num[VAL_W-1] ? (~req.num + 1'b1) : req.num;
      shifted = {rem_ff[VAL_W-1:0], dvd_ff[DW-1]};
      twice = {rem_ff, 1'b0};
      mag = quo_ff;
      if (req.start) begin
         neg_in = req.num[VAL_W-1];
         den_in = req.den;
         if (req.den == '0) begin
            done_in = 1'b1;
            res_in = (req.num == '0) ? '0 : (req.num[VAL_W-1] ? NEG_MAX : POS_MAX);
         end else begin
            busy_in = 1'b1;
            ovf_in = 1'b0;
            dvd_in = {fmag, {FRAC_BITS{1'b0}}};
            rem_in = '0; quo_in = '0;
            cnt_in = CW'(DW);
         end
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            dvd_in = {dvd_ff[DW-2:0], 1'b0};
            if (shifted >= {1'b0, den_ff}) begin
               rem_in = shifted - {1'b0, den_ff};
               quo_in = {quo_ff[VAL_W-1:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[VAL_W-1:0], 1'b0};
            end
            if (quo_in[VAL_W]) begin
               ovf_in = 1'b1;
               quo_in[VAL_W] = 1'b0;
            end
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (twice >= {2'b0, den_ff}) mag = quo_ff + 1'b1;
            if (neg_ff)
               res_in = (ovf_ff || mag >= {1'b0, NEG_MAX}) ? NEG_MAX : val_type'(-mag);
            else
               res_in = (ovf_ff || mag > {1'b0, POS_MAX}) ? POS_MAX : mag[VAL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      neg_ff <= neg_in; ovf_ff <= ovf_in; cnt_ff <= cnt_in; dvd_ff <= dvd_in;
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.busy = busy_ff;
   assign rsp.quot = res_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff || $past(req.start)) else $error("div done stuck");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.start) else $error("div restarted while busy");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= CW'(DW)) else $error("div count out of range");
endmodule

// ===== design/acvs_mul.sv =====
// Shared multiplier: wide signed product over four half-width partial products, round, saturate.
module acvs_mul #(
   parameter int FRAC_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  acvs_pkg::wide_type op_a,
   input  acvs_pkg::wide_type op_b,
   input  logic half,
   output logic done,
   output acvs_pkg::val_type result
);
   import acvs_pkg::*;
   localparam int HW = OP_W / 2;

   logic [2:0] ph_ff, ph_in;
   logic neg_ff, neg_in, half_ff, half_in;
   logic [OP_W-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [2*HW-1:0] pp;
   logic [HW-1:0] xa, xb;
   logic [PROD_W-1:0] ppx, rnd, sh;
   logic [PROD_W-1:0] rounded;
   logic done_ff, done_in;
   val_type res_ff, res_in;
   logic ovf;

   always_comb begin
      unique case (ph_ff)
         3'd1: begin xa = ma_ff[HW-1:0]; xb = mb_ff[HW-1:0]; end
         3'd2: begin xa = ma_ff[HW-1:0]; xb = mb_ff[OP_W-1:HW]; end
         3'd3: begin xa = ma_ff[OP_W-1:HW]; xb = mb_ff[HW-1:0]; end
         default: begin xa = ma_ff[OP_W-1:HW]; xb = mb_ff[OP_W-1:HW]; end
      endcase
   end

   assign pp = xa * xb;

   always_comb begin
      ph_in = ph_ff; neg_in = neg_ff; half_in = half_ff; ma_in = ma_ff; mb_in = mb_ff;
      acc_in = acc_ff; done_in = 1'b0; res_in = res_ff;
      ppx = '0; rnd = '0; sh = '0; rounded = '0; ovf = 1'b0;
      if (start) begin
         neg_in = op_a[OP_W-1] ^ op_b[OP_W-1];
         ma_in = op_a[OP_W-1] ? (~op_a + 1'b1) : op_a;
         mb_in = op_b[OP_W-1] ? (~op_b + 1'b1) : op_b;
         half_in = half;
         acc_in = '0;
         ph_in = 3'd1;
      end else if (ph_ff >= 3'd1 && ph_ff <= 3'd4) begin
         unique case (ph_ff)
            3'd1: ppx = {{(PROD_W-2*HW){1'b0}}, pp};
            3'd2, 3'd3: ppx = {{(PROD_W-3*HW){1'b0}}, pp, {HW{1'b0}}};
            default: ppx = {pp, {(2*HW){1'b0}}};
         endcase
         acc_in = acc_ff + ppx;
         ph_in = ph_ff + 1'b1;
      end else if (ph_ff == 3'd5) begin
         ph_in = 3'd0;
         done_in = 1'b1;
         rnd = half_ff ? (PROD_W'(1) << FRAC_BITS) : (PROD_W'(1) << (FRAC_BITS - 1));
         rounded = acc_ff + rnd;
         sh = half_ff ? (rounded >> (FRAC_BITS + 1)) : (rounded >> FRAC_BITS);
         ovf = |sh[PROD_W-1:VAL_W];
         if (neg_ff)
            res_in = (ovf || sh[VAL_W-1:0] >= NEG_MAX) ? NEG_MAX
                     : val_type'(-sh[VAL_W-1:0]);
         else
            res_in = (ovf || sh[VAL_W-1]) ? POS_MAX : sh[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= 3'd0; done_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in; done_ff <= done_in;
      end
      neg_ff <= neg_in; half_ff <= half_in; ma_ff <= ma_in; mb_ff <= mb_in;
      acc_ff <= acc_in; res_ff <= res_in;
   end

   assign done = done_ff;
   assign result = res_ff;

   a_phase: assert property (@(posedge clock) disable iff (reset)
      ph_ff <= 3'd5) else $error("mul phase out of range");
   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(ph_ff) == 3'd5) else $error("mul done without finish");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      ph_ff != 3'd0 |-> !start) else $error("mul restarted while busy");
endmodule

// ===== design/anharmonic_chain_verlet_step.sv =====
// Top level: stores, register file and sequencer of the chain integrator.
// A load request is taken while idle and busy stays low. A step request walks the
// chain in passes with one shared multiplier and one shared restoring divider. A
// force pass costs up to 4 products and one division per particle; each kick and
// the drift cost one product per particle, and a result pass ends the step. A step
// runs one more force pass first when accelerations are stale.
// Results leave one at a time with rsp_valid; the receiver cannot stall.
module anharmonic_chain_verlet_step #(
   parameter int NUM_PARTICLES = 32,
   parameter int FRAC_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_func,
   input  logic [5:0] req_particle_index,
   input  logic signed [47:0] req_load_position,
   input  logic signed [47:0] req_load_velocity,
   input  logic [47:0] req_load_mass,
   output logic rsp_valid,
   output logic [5:0] rsp_out_index,
   output logic signed [47:0] rsp_out_position,
   output logic signed [47:0] rsp_out_velocity,
   output logic rsp_last_particle,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [4:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);
   import acvs_pkg::*;
   localparam int IW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
   localparam int CW = IW + 1;

   localparam logic [4:0] S_IDLE = 5'd0, S_RDF = 5'd1, S_F0 = 5'd2, S_F1 = 5'd3,
      S_F2 = 5'd4, S_F3 = 5'd5, S_F4 = 5'd6, S_F5 = 5'd7, S_F6 = 5'd8,
      S_FD = 5'd9, S_FW = 5'd10, S_KR = 5'd11, S_K0 = 5'd12, S_K1 = 5'd13,
      S_DR = 5'd14, S_D0 = 5'd15, S_D1 = 5'd16, S_OR = 5'd17, S_O0 = 5'd18,
      S_FN = 5'd19, S_KN = 5'd20, S_DN = 5'd21;
   localparam logic [1:0] PH_PRE = 2'd0, PH_K1 = 2'd1, PH_DRIFT = 2'd2, PH_K2 = 2'd3;

   val_type pos_mem [NUM_PARTICLES];
   val_type vel_mem [NUM_PARTICLES];
   val_type acc_mem [NUM_PARTICLES];
   logic [VAL_W-1:0] mass_mem [NUM_PARTICLES];

   logic [47:0] kappa_ff, alpha_ff, dt_ff;
   logic [6:0] count_ff;
   logic accv_ff, accv_in;
   logic [4:0] st_ff, st_in;
   logic [1:0] ph_ff, ph_in;
   logic [CW-1:0] n_ff, n_in, i_ff, i_in;
   val_type left_ff, cur_ff, right_ff, pre_ff;
   val_type pr_ff, vr_ff, ar_ff;
   logic [VAL_W-1:0] mr_ff;
   val_type t1_ff, t1_in, t2_ff, t2_in;
   logic csr_wr;
   logic mstart;
   wide_type ma, mb;
   logic mhalf, mdone;
   val_type mres;
   div_req_type dreq;
   div_rsp_type drsp;
   logic [IW-1:0] ridx;
   logic pos_we, vel_we, acc_we;
   val_type pos_wd, vel_wd;
   logic [IW-1:0] widx;
   logic [CW-1:0] ip1;
   logic has_r, has_l;
   logic signed [VAL_W+1:0] lap, dr, dl, fsum;
   logic out_v_ff;
   logic [5:0] out_i_ff;
   logic out_l_ff;
   val_type out_p_ff, out_v2_ff;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign busy = (st_ff != S_IDLE);

   always_comb begin
      unique case (csr_paddr[4:3])
         REG_KAPPA: csr_prdata = {16'd0, kappa_ff};
         REG_ALPHA: csr_prdata = {{16{alpha_ff[47]}}, alpha_ff};
         REG_DT: csr_prdata = {16'd0, dt_ff};
         default: csr_prdata = {57'd0, count_ff};
      endcase
   end

   acvs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mstart), .op_a(ma), .op_b(mb),
      .half(mhalf), .done(mdone), .result(mres));

   acvs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign ip1 = i_ff + 1'b1;
   assign has_r = ip1 < n_ff;
   assign has_l = i_ff != '0;
   assign lap = {{2{left_ff[VAL_W-1]}}, left_ff} - {cur_ff[VAL_W-1], cur_ff, 1'b0}
                + {{2{right_ff[VAL_W-1]}}, right_ff};
   assign dr = {{2{right_ff[VAL_W-1]}}, right_ff} - {{2{cur_ff[VAL_W-1]}}, cur_ff};
   assign dl = {{2{cur_ff[VAL_W-1]}}, cur_ff} - {{2{left_ff[VAL_W-1]}}, left_ff};
   assign fsum = {{2{t1_ff[VAL_W-1]}}, t1_ff} + {{2{mres[VAL_W-1]}}, mres};

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; n_in = n_ff; i_in = i_ff; accv_in = accv_ff;
      t1_in = t1_ff; t2_in = t2_ff;
      mstart = 1'b0; ma = '0; mb = '0; mhalf = 1'b0;
      dreq = '0; ridx = i_ff[IW-1:0];
      pos_we = 1'b0; vel_we = 1'b0; acc_we = 1'b0; pos_wd = '0; vel_wd = '0;
      widx = i_ff[IW-1:0];
      unique case (st_ff)
         S_IDLE: begin
            ridx = '0;
            if (start) begin
               if (!req_func) begin
                  if (32'(req_particle_index) < NUM_PARTICLES) accv_in = 1'b0;
               end else begin
                  if (count_ff < 7'd2) n_in = CW'(2);
                  else if (32'(count_ff) > NUM_PARTICLES) n_in = CW'(NUM_PARTICLES);
                  else n_in = CW'(count_ff);
                  i_in = '0;
                  ph_in = accv_ff ? PH_K1 : PH_PRE;
                  st_in = accv_ff ? S_KR : S_RDF;
               end
            end
         end
         S_RDF: st_in = S_F0;
         S_F0: begin
            mstart = 1'b1; ma = {2'b00, kappa_ff}; mb = lap; st_in = S_F1;
         end
         S_F1: if (mdone) begin
            t1_in = mres;
            if (has_r) begin
               mstart = 1'b1; ma = dr; mb = dr;
            end
            st_in = S_F2;
         end
         S_F2: if (mdone || !has_r) begin
            t2_in = has_r ? mres : '0;
            if (has_l) begin
               mstart = 1'b1; ma = dl; mb = dl;
            end
            st_in = S_F3;
         end
         S_F3: if (mdone || !has_l) begin
            mstart = 1'b1; ma = {{2{alpha_ff[47]}}, alpha_ff};
            mb = {{2{t2_ff[VAL_W-1]}}, t2_ff}
                 - (has_l ? {{2{mres[VAL_W-1]}}, mres} : '0);
            st_in = S_F4;
         end
         S_F4: if (mdone) begin
            dreq.start = 1'b1; dreq.num = sat_wide(fsum); dreq.den = mr_ff;
            st_in = S_F5;
         end
         S_F5: if (drsp.done) begin
            acc_we = 1'b1;
            st_in = S_FN;
         end else st_in = S_F6;
         S_F6: if (drsp.done) begin
            acc_we = 1'b1;
            st_in = S_FN;
         end
         S_FN: begin
            if (has_r) begin
               i_in = ip1; ridx = ip1[IW-1:0]; st_in = S_FW;
            end else begin
               i_in = '0; ridx = '0; st_in = S_KR;
               ph_in = (ph_ff == PH_PRE) ? PH_K1 : PH_K2;
            end
         end
         S_FW: begin
            st_in = S_FD;
            ridx = (i_ff + 1'b1 < n_ff) ? IW'(i_ff + 1'b1) : i_ff[IW-1:0];
         end
         S_FD: st_in = S_F0;
         S_KR: st_in = S_K0;
         S_K0: begin
            mstart = 1'b1; ma = {2'b00, dt_ff}; mb = {{2{ar_ff[VAL_W-1]}}, ar_ff};
            mhalf = 1'b1; st_in = S_K1;
         end
         S_K1: if (mdone) begin
            vel_we = 1'b1;
            vel_wd = sat_wide({{2{vr_ff[VAL_W-1]}}, vr_ff} + {{2{mres[VAL_W-1]}}, mres});
            st_in = S_KN;
         end
         S_KN: begin
            if (has_r) begin
               i_in = ip1; ridx = ip1[IW-1:0]; st_in = S_KR;
            end else begin
               i_in = '0; ridx = '0;
               if (ph_ff == PH_K1) begin
                  ph_in = PH_DRIFT; st_in = S_DR;
               end else st_in = S_OR;
            end
         end
         S_DR: st_in = S_D0;
         S_D0: begin
            mstart = 1'b1; ma = {2'b00, dt_ff}; mb = {{2{vr_ff[VAL_W-1]}}, vr_ff};
            st_in = S_D1;
         end
         S_D1: if (mdone) begin
            pos_we = 1'b1;
            pos_wd = sat_wide({{2{pr_ff[VAL_W-1]}}, pr_ff} + {{2{mres[VAL_W-1]}}, mres});
            st_in = S_DN;
         end
         S_DN: begin
            if (has_r) begin
               i_in = ip1; ridx = ip1[IW-1:0]; st_in = S_DR;
            end else begin
               i_in = '0; ridx = '0; ph_in = PH_K2; st_in = S_RDF;
            end
         end
         S_OR: st_in = S_O0;
         S_O0: begin
            if (has_r) begin
               i_in = ip1; ridx = ip1[IW-1:0]; st_in = S_OR;
            end else begin
               accv_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
      if (csr_wr && (csr_paddr[4:3] == REG_KAPPA || csr_paddr[4:3] == REG_ALPHA
                     || csr_paddr[4:3] == REG_COUNT))
         accv_in = 1'b0;
   end

   // neighbor window: left/cur/right shift as the force pass advances
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; accv_ff <= 1'b0; out_v_ff <= 1'b0;
         kappa_ff <= 48'h0001_0000_0000; alpha_ff <= '0;
         dt_ff <= 48'd42949673; count_ff <= 7'd32;
      end else begin
         st_ff <= st_in; accv_ff <= accv_in;
         out_v_ff <= (st_ff == S_O0);
         if (csr_wr) begin
            unique case (csr_paddr[4:3])
               REG_KAPPA: kappa_ff <= csr_pwdata[47:0];
               REG_ALPHA: alpha_ff <= csr_pwdata[47:0];
               REG_DT: dt_ff <= csr_pwdata[47:0];
               default: count_ff <= csr_pwdata[6:0];
            endcase
         end
      end
      ph_ff <= ph_in; n_ff <= n_in; i_ff <= i_in; t1_ff <= t1_in; t2_ff <= t2_in;
      pr_ff <= pos_mem[ridx]; vr_ff <= vel_mem[ridx]; ar_ff <= acc_mem[ridx];
      mr_ff <= mass_mem[ridx];
      if (st_ff == S_RDF) begin
         left_ff <= '0;
         cur_ff <= pos_mem[0];
         right_ff <= (n_ff > CW'(1)) ? pos_mem[1] : '0;
      end else if (st_ff == S_FD) begin
         left_ff <= cur_ff;
         cur_ff <= right_ff;
         right_ff <= has_r ? pre_ff : '0;
      end
      pre_ff <= pos_mem[ridx];
      if (st_ff == S_IDLE && start && !req_func
          && 32'(req_particle_index) < NUM_PARTICLES) begin
         pos_mem[req_particle_index[IW-1:0]] <= req_load_position;
         vel_mem[req_particle_index[IW-1:0]] <= req_load_velocity;
         mass_mem[req_particle_index[IW-1:0]] <= req_load_mass;
      end
      if (pos_we) pos_mem[widx] <= pos_wd;
      if (vel_we) vel_mem[widx] <= vel_wd;
      if (acc_we) acc_mem[widx] <= drsp.quot;
      out_i_ff <= 6'(i_ff);
      out_l_ff <= !has_r;
      out_p_ff <= pr_ff;
      out_v2_ff <= vr_ff;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_out_index = out_i_ff;
   assign rsp_out_position = out_p_ff;
   assign rsp_out_velocity = out_v2_ff;
   assign rsp_last_particle = out_l_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> i_ff < n_ff) else $error("particle index beyond count");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_particle |-> !busy) else $error("last result while busy");
   a_valid_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_particle && !csr_wr |-> accv_ff) else $error("acc flag lost");
   a_n_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> n_ff >= CW'(2)) else $error("count below two");
endmodule

// ===== dv/chain_step_checker.sv =====
// Checker for the chain integrator: tracks registers and stores, predicts results, compares.
module chain_step_checker (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  logic req_func,
   input  logic [5:0] req_particle_index,
   input  logic signed [47:0] req_load_position,
   input  logic signed [47:0] req_load_velocity,
   input  logic [47:0] req_load_mass,
   input  logic rsp_valid,
   input  logic [5:0] rsp_out_index,
   input  logic signed [47:0] rsp_out_position,
   input  logic signed [47:0] rsp_out_velocity,
   input  logic rsp_last_particle,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [4:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic csr_pready,
   output int errors,
   output int outstanding
);
   import acvs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHAIN_SIZE = 32;
   localparam int FRAC = 32;
   localparam logic signed [63:0] WIDE_MAX = 64'sd140737488355327;
   localparam logic signed [63:0] WIDE_MIN = -64'sd140737488355328;

   typedef struct {
      logic [5:0] index;
      val_type position;
      val_type velocity;
      logic last;
   } particle_state_type;

   val_type position_mem [CHAIN_SIZE];
   val_type velocity_mem [CHAIN_SIZE];
   val_type accel_mem [CHAIN_SIZE];
   logic [47:0] mass_mem [CHAIN_SIZE];
   logic accel_fresh;
   logic [47:0] kappa;
   val_type alpha;
   logic [47:0] dt;
   logic [6:0] count;
   particle_state_type expected_particles [$];

   assign outstanding = expected_particles.size();

   function automatic val_type signed_limit(input logic neg, input logic [127:0] mag);
      val_type r;
      if (neg) begin
         if (mag >= 128'h8000_0000_0000) r = NEG_MAX;
         else r = -$signed(mag[47:0]);
      end else begin
         if (mag > 128'h7FFF_FFFF_FFFF) r = POS_MAX;
         else r = mag[47:0];
      end
      return r;
   endfunction

   function automatic val_type clamp_sum(input logic signed [63:0] x);
      val_type r;
      if (x > WIDE_MAX) r = POS_MAX;
      else if (x < WIDE_MIN) r = NEG_MAX;
      else r = x[47:0];
      return r;
   endfunction

   function automatic val_type scaled_product(input logic signed [63:0] a,
                                              input logic signed [63:0] b, input int sh);
      logic neg;
      logic [63:0] ua, ub;
      logic [127:0] mag;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      mag = {64'b0, ua} * {64'b0, ub};
      mag = (mag + (128'd1 << (sh - 1))) >> sh;
      return signed_limit(neg, mag);
   endfunction

   function automatic val_type force_over_mass(input val_type f, input logic [47:0] m);
      logic [127:0] num, quo, rem;
      logic signed [63:0] fw;
      if (m == 0) begin
         if (f > 0) return POS_MAX;
         if (f < 0) return NEG_MAX;
         return '0;
      end
      fw = f;
      num = {64'b0, ((fw < 0) ? -fw : fw)} << FRAC;
      quo = num / {80'b0, m};
      rem = num % {80'b0, m};
      if ((rem << 1) >= {80'b0, m}) quo = quo + 1;
      return signed_limit(f < 0, quo);
   endfunction

   function automatic int active_count();
      if (count < 2) return 2;
      if (count > CHAIN_SIZE) return CHAIN_SIZE;
      return count;
   endfunction

   task automatic update_accelerations(input int n);
      logic signed [63:0] ui, lf, rt, lap, dr, dl;
      val_type harm, sq_r, sq_l, anh;
      for (int i = 0; i < n; i++) begin
         ui = position_mem[i];
         lf = (i > 0) ? position_mem[i-1] : 0;
         rt = (i + 1 < n) ? position_mem[i+1] : 0;
         lap = lf - 2 * ui + rt;
         dr = rt - ui;
         dl = ui - lf;
         harm = scaled_product($signed({16'b0, kappa}), lap, FRAC);
         sq_r = (i + 1 < n) ? scaled_product(dr, dr, FRAC) : '0;
         sq_l = (i > 0) ? scaled_product(dl, dl, FRAC) : '0;
         anh = scaled_product(alpha, 64'(sq_r) - 64'(sq_l), FRAC);
         accel_mem[i] = force_over_mass(clamp_sum(64'(harm) + 64'(anh)), mass_mem[i]);
      end
   endtask

   task automatic kick_velocities(input int n);
      for (int i = 0; i < n; i++)
         velocity_mem[i] = clamp_sum(64'(velocity_mem[i]) +
            64'(scaled_product($signed({16'b0, dt}), accel_mem[i], FRAC + 1)));
   endtask

   task automatic advance_chain();
      int n;
      particle_state_type p;
      n = active_count();
      if (!accel_fresh) update_accelerations(n);
      kick_velocities(n);
      for (int i = 0; i < n; i++)
         position_mem[i] = clamp_sum(64'(position_mem[i]) +
            64'(scaled_product($signed({16'b0, dt}), velocity_mem[i], FRAC)));
      update_accelerations(n);
      kick_velocities(n);
      accel_fresh = 1'b1;
      for (int i = 0; i < n; i++) begin
         p.index = i[5:0];
         p.position = position_mem[i];
         p.velocity = velocity_mem[i];
         p.last = (i + 1 == n);
         expected_particles.push_back(p);
      end
   endtask

   always @(posedge clock) begin
      particle_state_type p;
      if (reset) begin
         kappa <= 48'h1_0000_0000;
         alpha <= '0;
         dt <= 48'd42949673;
         count <= 7'd32;
         accel_fresh <= 1'b0;
         errors <= 0;
         expected_particles.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:3])
               REG_KAPPA: begin
                  kappa = csr_pwdata[47:0];
                  accel_fresh = 1'b0;
               end
               REG_ALPHA: begin
                  alpha = csr_pwdata[47:0];
                  accel_fresh = 1'b0;
               end
               REG_DT: dt = csr_pwdata[47:0];
               REG_COUNT: begin
                  count = csr_pwdata[6:0];
                  accel_fresh = 1'b0;
               end
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_func) advance_chain();
            else if (req_particle_index < CHAIN_SIZE) begin
               position_mem[req_particle_index[4:0]] = req_load_position;
               velocity_mem[req_particle_index[4:0]] = req_load_velocity;
               mass_mem[req_particle_index[4:0]] = req_load_mass;
               accel_fresh = 1'b0;
            end
         end
         if (rsp_valid) begin
            if (expected_particles.size() == 0) begin
               $display("%0t: unexpected result for particle %0d", $time, rsp_out_index);
               errors <= errors + 1;
            end else begin
               p = expected_particles.pop_front();
               if (rsp_out_index !== p.index || rsp_out_position !== p.position ||
                   rsp_out_velocity !== p.velocity || rsp_last_particle !== p.last) begin
                  $display("%0t: mismatch expected idx %0d pos %h vel %h last %b", $time,
                           p.index, p.position, p.velocity, p.last);
                  $display("%0t:            actual idx %0d pos %h vel %h last %b", $time,
                           rsp_out_index, rsp_out_position, rsp_out_velocity,
                           rsp_last_particle);
                  errors <= errors + 1;
               end
            end
         end
      end
   end
endmodule

// ===== dv/testbench.sv =====
// Testbench top: clock, reset, request and register stimulus, and the verdict.
module testbench;
   import acvs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = 1'b0;
   logic [5:0] req_particle_index = '0;
   logic signed [47:0] req_load_position = '0;
   logic signed [47:0] req_load_velocity = '0;
   logic [47:0] req_load_mass = '0;
   logic rsp_valid;
   logic [5:0] rsp_out_index;
   logic signed [47:0] rsp_out_position;
   logic signed [47:0] rsp_out_velocity;
   logic rsp_last_particle;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;
   int errors;
   int outstanding;
   int idle_pct = 0;
   int quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   anharmonic_chain_verlet_step dut (.*);

   chain_step_checker checker_inst (.*);

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_psel && csr_penable)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic send_request(input logic func, input logic [5:0] index,
                               input logic [47:0] pos, input logic [47:0] vel,
                               input logic [47:0] mass);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_particle_index <= index;
      req_load_position <= pos;
      req_load_velocity <= vel;
      req_load_mass <= mass;
      do @(posedge clock); while (busy);
   endtask

   task automatic load_particle(input logic [5:0] index, input logic [47:0] pos,
                                input logic [47:0] vel, input logic [47:0] mass);
      send_request(1'b0, index, pos, vel, mass);
   endtask

   task automatic step_chain();
      send_request(1'b1, 6'($urandom_range(63)), 48'({$urandom, $urandom}),
                   48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (busy || outstanding != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [47:0] value);
      logic [15:0] upper;
      upper = 16'($urandom);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= {upper, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [47:0] random_value();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(7))
         0: return POS_MAX;
         1: return NEG_MAX;
         2: return '0;
         3: return w[47:0];
         default: return {{17{w[31]}}, w[30:0]};
      endcase
   endfunction

   function automatic logic [47:0] random_mass();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(9))
         0: return '0;
         1: return 48'hFFFF_FFFF_FFFF;
         2: return w[47:0];
         default: return {12'b0, w[35:0]} + 48'h1_0000_0000;
      endcase
   endfunction

   task automatic run_phase(input logic [47:0] k, input logic [47:0] a, input logic [47:0] d,
                            input logic [6:0] cnt, input int pct, input int items);
      int n, done, step_pct;
      logic [5:0] index;
      drain();
      write_reg(REG_KAPPA, k);
      write_reg(REG_ALPHA, a);
      write_reg(REG_DT, d);
      write_reg(REG_COUNT, {41'b0, cnt});
      idle_pct = pct;
      n = (cnt < 2) ? 2 : (cnt > 32) ? 32 : cnt;
      step_pct = (n > 8) ? 6 : 30;
      for (int i = 0; i < n; i++)
         load_particle(i[5:0], random_value(), random_value(), random_mass());
      done = n;
      while (done < items) begin
         if ($urandom_range(99) < step_pct) begin
            step_chain();
            done++;
         end else if ($urandom_range(19) == 0) begin
            index = 6'($urandom_range(32, 63));
            load_particle(index, random_value(), random_value(), random_mass());
         end else begin
            index = 6'(($urandom_range(9) == 0) ? $urandom_range(31)
                                                 : $urandom_range(n - 1));
            load_particle(index, random_value(), random_value(), random_mass());
            done++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_reg(REG_KAPPA, 48'hFFFF_FFFF_FFFF);
      write_reg(REG_ALPHA, NEG_MAX);
      write_reg(REG_DT, 48'h1_0000_0000);
      write_reg(REG_COUNT, 48'd0);
      load_particle(6'd63, POS_MAX, POS_MAX, 48'h1_0000_0000);
      load_particle(6'd0, POS_MAX, NEG_MAX, 48'd0);
      load_particle(6'd1, NEG_MAX, POS_MAX, 48'hFFFF_FFFF_FFFF);
      step_chain();
      step_chain();
      load_particle(6'd1, 48'd0, 48'd0, 48'd0);
      load_particle(6'd0, 48'd0, 48'd0, 48'd0);
      step_chain();
      load_particle(6'd0, 48'h1_0000_0000, -48'sh1_0000_0000, 48'h1_0000_0000);
      load_particle(6'd1, -48'sh1_0000_0000, 48'd0, 48'h8000_0000);
      step_chain();
      step_chain();
      run_phase(48'h1_0000_0000, 48'd0, 48'd42949673, 7'd5, 0, 112);
      run_phase(48'hFFFF_FFFF_FFFF, NEG_MAX, 48'hFFFF_FFFF_FFFF, 7'd1, 72, 112);
      run_phase(48'd0, POS_MAX, 48'd0, 7'd127, 0, 100);
      run_phase(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                {28'b0, 20'($urandom)}, 7'd3, 38, 112);
      drain();
      if (errors == 0 && outstanding == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
